// ----- rtl/complex_arithmetic_unit_assert.svh -----
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CAU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, prop, msg)
`define CAU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/cau_pkg.sv -----
// Shared types, codes and helper functions of the complex arithmetic unit.
`default_nettype none
package cau_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int Q_BITS = 32;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_CONJ = 3'd4;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DZ  = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  st;
		logic        is_div;
	} side_t;

	typedef struct packed {
		logic [63:0] m_re;
		logic [63:0] m_im;
		logic        neg_re;
		logic        neg_im;
		logic [63:0] d;
	} div_in_t;

	typedef struct packed {
		logic [31:0] q;
		logic        ovf;
		logic        neg;
	} quo_t;

	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > 66'sd2147483647) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (v < -66'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	function automatic logic [32:0] fin_quo(input quo_t x);
		logic [32:0] mag;
		logic [32:0] neg_mag;
		logic [32:0] r;
		mag = x.ovf ? 33'h1_0000_0000 : {1'b0, x.q};
		neg_mag = -mag;
		if (x.neg) begin
			if (mag > 33'h0_8000_0000) begin
				r = {1'b1, 32'h8000_0000};
			end else begin
				r = {1'b0, neg_mag[31:0]};
			end
		end else begin
			if (mag > 33'h0_7fff_ffff) begin
				r = {1'b1, 32'h7fff_ffff};
			end else begin
				r = {1'b0, mag[31:0]};
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/cau_front.sv -----
// Front stages: operand products, sums, simple results and divider setup.
`default_nettype none
module cau_front import cau_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         req_type,
	input  wire logic signed [31:0] a_re,
	input  wire logic signed [31:0] a_im,
	input  wire logic signed [31:0] b_re,
	input  wire logic signed [31:0] b_im,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output side_t                   side,
	output div_in_t                 dv
);
	logic v_s1, v_s2, ld_s1, ld_s2;
	logic [2:0] op_s1;
	logic signed [63:0] prr_s1, pii_s1, pri_s1, pir_s1, br2_s1, bi2_s1;
	logic signed [32:0] sre_s1, sim_s1;
	logic signed [32:0] sre, sim;
	side_t side_s2, side_n;
	div_in_t dv_s2, dv_n;
	logic signed [64:0] smr, smi, nre, nim, neg_nre, neg_nim;
	logic signed [65:0] tr, ti;
	logic [63:0] dsum;
	logic [32:0] sr, si, mr, mi;

	assign ld_s2 = ~v_s2 | out_ready;
	assign ld_s1 = ~v_s1 | ld_s2;
	assign in_ready = ld_s1;

	always_comb begin
		case (req_type)
			OP_ADD: begin
				sre = 33'(a_re) + 33'(b_re);
				sim = 33'(a_im) + 33'(b_im);
			end
			OP_SUB: begin
				sre = 33'(a_re) - 33'(b_re);
				sim = 33'(a_im) - 33'(b_im);
			end
			OP_CONJ: begin
				sre = 33'(a_re);
				sim = -33'(a_im);
			end
			default: begin
				sre = '0;
				sim = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			op_s1 <= req_type;
			prr_s1 <= a_re * b_re;
			pii_s1 <= a_im * b_im;
			pri_s1 <= a_re * b_im;
			pir_s1 <= a_im * b_re;
			br2_s1 <= b_re * b_re;
			bi2_s1 <= b_im * b_im;
			sre_s1 <= sre;
			sim_s1 <= sim;
		end
	end

	assign smr = 65'(prr_s1) - 65'(pii_s1);
	assign smi = 65'(pri_s1) + 65'(pir_s1);
	assign nre = 65'(prr_s1) + 65'(pii_s1);
	assign nim = 65'(pir_s1) - 65'(pri_s1);
	assign neg_nre = -nre;
	assign neg_nim = -nim;
	assign tr = 66'(smr) >>> FRAC_BITS;
	assign ti = 66'(smi) >>> FRAC_BITS;
	assign dsum = $unsigned(br2_s1) + $unsigned(bi2_s1);
	assign sr = sat32(66'(sre_s1));
	assign si = sat32(66'(sim_s1));
	assign mr = sat32(tr);
	assign mi = sat32(ti);

	always_comb begin
		side_n = '0;
		case (op_s1)
			OP_ADD, OP_SUB, OP_CONJ: begin
				side_n.re = sr[31:0];
				side_n.im = si[31:0];
				side_n.st = (sr[32] | si[32]) ? ST_SAT : ST_OK;
			end
			OP_MUL: begin
				side_n.re = mr[31:0];
				side_n.im = mi[31:0];
				side_n.st = (mr[32] | mi[32]) ? ST_SAT : ST_OK;
			end
			OP_DIV: begin
				if (dsum == 64'd0) begin
					side_n.st = ST_DZ;
				end else begin
					side_n.is_div = 1'b1;
				end
			end
			default: begin
				side_n = '0;
			end
		endcase
		dv_n.neg_re = nre[64];
		dv_n.neg_im = nim[64];
		dv_n.m_re = nre[64] ? neg_nre[63:0] : nre[63:0];
		dv_n.m_im = nim[64] ? neg_nim[63:0] : nim[63:0];
		dv_n.d = dsum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2 && v_s1) begin
			side_s2 <= side_n;
			dv_s2 <= dv_n;
		end
	end

	assign out_valid = v_s2;
	assign side = side_s2;
	assign dv = dv_s2;
endmodule
`default_nettype wire

// ----- rtl/cau_div.sv -----
// Pipelined restoring divider, one quotient bit per stage for both parts.
`default_nettype none
module cau_div import cau_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire side_t   side_in,
	input  wire div_in_t dv,
	output logic         out_valid,
	input  wire logic    out_ready,
	output side_t        side_out,
	output quo_t         quo_re,
	output quo_t         quo_im
);
	localparam int NS = Q_BITS;
	localparam int NW = 64 + FRAC_BITS;

	logic [NS:0] v;
	logic [NS+1:0] ld;
	side_t side_p [0:NS];
	logic [63:0] d_p [0:NS];
	logic [63:0] rre_p [0:NS];
	logic [63:0] rim_p [0:NS];
	logic [31:0] lre_p [0:NS];
	logic [31:0] lim_p [0:NS];
	logic [31:0] qre_p [0:NS];
	logic [31:0] qim_p [0:NS];
	logic ovfre_p [0:NS];
	logic ovfim_p [0:NS];
	logic negre_p [0:NS];
	logic negim_p [0:NS];
	logic [NW-1:0] nre_w, nim_w;
	logic [63:0] hre, him;

	assign ld[NS+1] = out_ready;
	assign in_ready = ld[0];

	assign nre_w = NW'(dv.m_re) << FRAC_BITS;
	assign nim_w = NW'(dv.m_im) << FRAC_BITS;
	assign hre = 64'(nre_w[NW-1:32]);
	assign him = 64'(nim_w[NW-1:32]);

	genvar k;
	generate
		for (k = 0; k <= NS; k++) begin : g_stage
			assign ld[k] = ~v[k] | ld[k+1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v[k] <= 1'b0;
				end else if (ld[k]) begin
					v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k-1];
				end
			end
			if (k == 0) begin : g_setup
				always_ff @(posedge clk) begin
					if (ld[0] && in_valid) begin
						side_p[0] <= side_in;
						d_p[0] <= dv.d;
						rre_p[0] <= hre;
						rim_p[0] <= him;
						lre_p[0] <= nre_w[31:0];
						lim_p[0] <= nim_w[31:0];
						qre_p[0] <= '0;
						qim_p[0] <= '0;
						ovfre_p[0] <= hre >= dv.d;
						ovfim_p[0] <= him >= dv.d;
						negre_p[0] <= dv.neg_re;
						negim_p[0] <= dv.neg_im;
					end
				end
			end else begin : g_step
				logic [64:0] tre, tim, dre, dim;
				logic gre, gim;
				assign tre = {rre_p[k-1], lre_p[k-1][31]};
				assign tim = {rim_p[k-1], lim_p[k-1][31]};
				assign gre = tre >= {1'b0, d_p[k-1]};
				assign gim = tim >= {1'b0, d_p[k-1]};
				assign dre = tre - {1'b0, d_p[k-1]};
				assign dim = tim - {1'b0, d_p[k-1]};
				always_ff @(posedge clk) begin
					if (ld[k] && v[k-1]) begin
						side_p[k] <= side_p[k-1];
						d_p[k] <= d_p[k-1];
						rre_p[k] <= gre ? dre[63:0] : tre[63:0];
						rim_p[k] <= gim ? dim[63:0] : tim[63:0];
						lre_p[k] <= {lre_p[k-1][30:0], 1'b0};
						lim_p[k] <= {lim_p[k-1][30:0], 1'b0};
						qre_p[k] <= {qre_p[k-1][30:0], gre};
						qim_p[k] <= {qim_p[k-1][30:0], gim};
						ovfre_p[k] <= ovfre_p[k-1];
						ovfim_p[k] <= ovfim_p[k-1];
						negre_p[k] <= negre_p[k-1];
						negim_p[k] <= negim_p[k-1];
					end
				end
			end
		end
	endgenerate

	assign out_valid = v[NS];
	assign side_out = side_p[NS];
	assign quo_re = '{q: qre_p[NS], ovf: ovfre_p[NS], neg: negre_p[NS]};
	assign quo_im = '{q: qim_p[NS], ovf: ovfim_p[NS], neg: negim_p[NS]};
endmodule
`default_nettype wire

// ----- rtl/cau_back.sv -----
// Output stage: quotient sign and saturation, result selection, output register.
`default_nettype none
module cau_back import cau_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire side_t  side,
	input  wire quo_t   quo_re,
	input  wire quo_t   quo_im,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [31:0] res_re,
	output logic [31:0] res_im,
	output logic [1:0]  status
);
	logic v_s1, ld_s1;
	logic [32:0] fr, fi;
	logic [31:0] re_n, im_n, re_s1, im_s1;
	logic [1:0] st_n, st_s1;

	assign ld_s1 = ~v_s1 | out_ready;
	assign in_ready = ld_s1;
	assign fr = fin_quo(quo_re);
	assign fi = fin_quo(quo_im);

	always_comb begin
		if (side.is_div) begin
			re_n = fr[31:0];
			im_n = fi[31:0];
			st_n = (fr[32] | fi[32]) ? ST_SAT : ST_OK;
		end else begin
			re_n = side.re;
			im_n = side.im;
			st_n = side.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			re_s1 <= re_n;
			im_s1 <= im_n;
			st_s1 <= st_n;
		end
	end

	assign out_valid = v_s1;
	assign res_re = re_s1;
	assign res_im = im_s1;
	assign status = st_s1;
endmodule
`default_nettype wire

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit top level: add, subtract, multiply, divide, conjugate.
// Takes one request per cycle when the output is not held back. The divider
// produces one quotient bit per stage over 32 stages; besides these there are
// two front stages for the products and sums, one divider setup stage and
// the output register. Every stage holds its item under back pressure and
// bubbles are squeezed out.
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic [2:0]         req_type,
	input  wire logic signed [31:0] a_re,
	input  wire logic signed [31:0] a_im,
	input  wire logic signed [31:0] b_re,
	input  wire logic signed [31:0] b_im,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic signed [31:0]      res_re,
	output logic signed [31:0]      res_im,
	output logic [1:0]              status
);
	logic f_valid, f_ready, d_valid, d_ready;
	side_t f_side, d_side;
	div_in_t f_dv;
	quo_t q_re, q_im;
	logic [31:0] o_re, o_im;

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_valid), .in_ready(req_ready),
		.req_type(req_type), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_valid(f_valid), .out_ready(f_ready),
		.side(f_side), .dv(f_dv)
	);

	cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready),
		.side_in(f_side), .dv(f_dv),
		.out_valid(d_valid), .out_ready(d_ready),
		.side_out(d_side), .quo_re(q_re), .quo_im(q_im)
	);

	cau_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(d_valid), .in_ready(d_ready),
		.side(d_side), .quo_re(q_re), .quo_im(q_im),
		.out_valid(res_valid), .out_ready(res_ready),
		.res_re(o_re), .res_im(o_im), .status(status)
	);

	assign res_re = o_re;
	assign res_im = o_im;

	`CAU_ASSERT(a_dz_zero, res_valid && status == ST_DZ |-> res_re == 32'sd0 && res_im == 32'sd0, "divide by zero result not zero")
	`CAU_ASSERT(a_status_code, res_valid |-> status == ST_OK || status == ST_DZ || status == ST_SAT, "bad status code")
	`CAU_ASSERT_ALWAYS(a_empty_ready, !res_valid |-> req_ready, "request refused with empty output")
endmodule
`default_nettype wire
